// ----- sv/ldf_pkg.sv -----
package ldf_pkg;

  // Store geometry and field widths.
  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 2);
  localparam int SUM0_W = 35;
  localparam int SUM1_W = 46;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_SPAN = 2'd2;
  localparam logic [1:0] ST_OVFL = 2'd3;

  typedef struct packed {
    logic signed [31:0] time_stamp;
    logic signed [23:0] sample_value;
    logic               last_sample;
  } item_t;

  typedef struct packed {
    logic signed [63:0] slope;
    logic signed [63:0] intercept;
    logic [63:0]        residual_variance;
    logic [1:0]         status;
  } result_t;

  // One finished block as handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic signed [SUM0_W-1:0] s0;
    logic signed [SUM1_W-1:0] s1;
    logic signed [31:0]       t_first;
    logic signed [31:0]       t_last;
  } job_t;

  // Read request into the sample store.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } rd_req_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_SWEEP,
    BK_PREP,
    BK_PREP2,
    BK_MUL_A,
    BK_MUL_B1,
    BK_MUL_B2,
    BK_MUL_C,
    BK_NUM1,
    BK_NUM2,
    BK_DIV_V,
    BK_SLOPE,
    BK_DIV_S,
    BK_MUL_P,
    BK_MUL_Q,
    BK_ISUB,
    BK_DIV_I,
    BK_OUT
  } back_state_t;

endpackage

// ----- sv/ldf_front.sv -----
module ldf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  ldf_pkg::item_t         item,
  output logic                   push,
  output ldf_pkg::job_t          job,
  input  logic                   store_free,
  input  ldf_pkg::rd_req_t       rd_req,
  output logic signed [23:0]     rd_data
);

  logic signed [23:0] store [ldf_pkg::MAX_POINTS];

  logic [ldf_pkg::CNT_W-1:0]         count, count_next;
  logic signed [ldf_pkg::SUM0_W-1:0] s0, s0_next;
  logic signed [ldf_pkg::SUM1_W-1:0] s1, s1_next;
  logic signed [31:0]                t_first, t_first_next;
  logic                              hold;
  logic                              accept;
  logic                              room;
  logic signed [ldf_pkg::SUM1_W-1:0] idx_prod;

  assign accept = start & ~hold;
  assign busy = hold;
  assign room = count < ldf_pkg::CNT_W'(ldf_pkg::MAX_POINTS);
  assign idx_prod = $signed({1'b0, count[ldf_pkg::ADDR_W-1:0]}) * item.sample_value;
  assign push = accept & item.last_sample;

  // Running sums and count for the sample being transferred.
  always_comb begin
    t_first_next = (count == '0) ? item.time_stamp : t_first;
    if (room) begin
      count_next = count + 1'b1;
      s0_next = s0 + ldf_pkg::SUM0_W'(item.sample_value);
      s1_next = s1 + idx_prod;
    end else begin
      count_next = ldf_pkg::CNT_W'(ldf_pkg::MAX_POINTS + 1);
      s0_next = s0;
      s1_next = s1;
    end
    job = '{count: count_next, s0: s0_next, s1: s1_next,
            t_first: t_first_next, t_last: item.time_stamp};
  end

  // Block state; sums clear once a block is handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      s0 <= '0;
      s1 <= '0;
      t_first <= '0;
      hold <= 1'b0;
    end else begin
      if (accept) begin
        t_first <= t_first_next;
        if (item.last_sample) begin
          count <= '0;
          s0 <= '0;
          s1 <= '0;
        end else begin
          count <= count_next;
          s0 <= s0_next;
          s1 <= s1_next;
        end
      end
      // The store stays locked until the back has swept it or has rejected the block.
      if (push) begin
        hold <= 1'b1;
      end else if (store_free) begin
        hold <= 1'b0;
      end
    end
  end

  // Sample store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (accept && room) begin
      store[count[ldf_pkg::ADDR_W-1:0]] <= item.sample_value;
    end
    if (rd_req.rd_en) begin
      rd_data <= store[rd_req.rd_addr];
    end
  end

endmodule

// ----- sv/ldf_queue.sv -----
module ldf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ldf_pkg::job_t  din,
  input  logic           pop,
  output logic           empty,
  output logic           full,
  output ldf_pkg::job_t  head
);

  ldf_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          do_push;
  logic          do_pop;

  assign empty = (fill == 2'd0);
  assign full = (fill == 2'd2);
  assign head = slots[rd_ptr];
  assign do_push = push & ~full;
  assign do_pop = pop & ~empty;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ----- sv/ldf_mul.sv -----
module ldf_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [127:0] a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] p
);

  logic [127:0] acc;
  logic [127:0] a_sh;
  logic [63:0]  b_sh;
  logic [6:0]   cnt;
  logic         running;

  assign p = acc;

  // Shift-and-add, one multiplier bit per cycle, product modulo 2^128.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= 7'd64;
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      a_sh <= a;
      b_sh <= b;
    end else if (running) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= {a_sh[126:0], 1'b0};
      b_sh <= {1'b0, b_sh[63:1]};
    end
  end

endmodule

// ----- sv/ldf_div.sv -----
module ldf_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [127:0] num,
  input  logic [127:0] den,
  output logic         done,
  output logic [127:0] quo,
  output logic         rem_nz
);

  logic [127:0] rem;
  logic [127:0] q;
  logic [127:0] dv;
  logic [7:0]   cnt;
  logic         running;
  logic [128:0] rs;
  logic [128:0] rs_sub;
  logic         ge;

  assign quo = q;
  assign rem_nz = |rem;
  assign rs = {rem, q[127]};
  assign rs_sub = rs - {1'b0, dv};
  assign ge = (rs >= {1'b0, dv});

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt <= 8'd128;
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == 8'd1) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      q <= num;
      dv <= den;
    end else if (running) begin
      rem <= ge ? rs_sub[127:0] : rs[127:0];
      q <= {q[126:0], ge};
    end
  end

endmodule

// ----- sv/ldf_back.sv -----
module ldf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  ldf_pkg::job_t        q_head,
  output logic                 pop,
  output logic                 store_free,
  output ldf_pkg::rd_req_t     rd_req,
  input  logic signed [23:0]   rd_data,
  output logic                 done,
  output ldf_pkg::result_t     result
);

  ldf_pkg::back_state_t state, state_next;

  logic [ldf_pkg::CNT_W-1:0]         n;
  logic signed [ldf_pkg::SUM0_W-1:0] s0;
  logic signed [ldf_pkg::SUM1_W-1:0] s1;
  logic signed [31:0]                tf;
  logic signed [31:0]                tl;
  logic [ldf_pkg::CNT_W-1:0]         idx;
  logic                              rd_v;
  logic                              sq_v;
  logic [46:0]                       sq;
  logic [56:0]                       syy;
  logic [20:0]                       nn1;
  logic [20:0]                       nnp1;
  logic [30:0]                       m;
  logic signed [47:0]                d;
  logic signed [32:0]                dx;
  logic signed [32:0]                ts;
  logic signed [47:0]                pn;
  logic [127:0]                      t_a;
  logic [127:0]                      t_b;
  logic [127:0]                      t_c;
  logic [127:0]                      den_v;
  logic                              neg_s;
  logic                              launched;
  ldf_pkg::result_t                  res;

  // Combinational helpers.
  logic                              head_short;
  logic                              sweep_end;
  logic signed [47:0]                sq_full;
  logic [ldf_pkg::CNT_W-1:0]         n_m1;
  logic [ldf_pkg::CNT_W:0]           n_p1;
  logic [21:0]                       nsq;
  logic [21:0]                       nnp1_calc;
  logic signed [47:0]                nm1_s0;
  logic signed [47:0]                d_calc;
  logic signed [32:0]                dx_calc;
  logic signed [32:0]                ts_calc;
  logic signed [47:0]                pn_calc;
  logic [31:0]                       m_calc;
  logic [41:0]                       mden;
  logic [ldf_pkg::SUM0_W-1:0]        s0_mag;
  logic [47:0]                       d_mag;
  logic [49:0]                       d3_mag;
  logic [32:0]                       dx_mag;
  logic [32:0]                       ts_mag;
  logic [47:0]                       pn_mag;
  logic [53:0]                       den_s;
  logic [127:0]                      diff_v;
  logic                              p_neg;
  logic                              b_neg;
  logic [127:0]                      i_mag;
  logic                              i_neg;
  logic                              is_mul;
  logic                              is_div;
  logic                              mul_go;
  logic                              div_go;
  logic [127:0]                      mul_a;
  logic [63:0]                       mul_b;
  logic                              mul_done;
  logic [127:0]                      mul_p;
  logic                              div_done;
  logic [127:0]                      div_q;
  logic                              div_nz;

  // Floor quotient with sign, saturated to the signed 64-bit range.
  function automatic logic [63:0] sat_quo(input logic [127:0] q, input logic nz,
                                          input logic neg);
    logic [127:0] qr;
    logic [63:0]  r;
    begin
      qr = q + 128'(neg & nz);
      if (!neg) begin
        r = (|q[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
      end else if ((|qr[127:64]) || (qr[63:0] > 64'h8000_0000_0000_0000)) begin
        r = 64'h8000_0000_0000_0000;
      end else begin
        r = 64'd0 - qr[63:0];
      end
      return r;
    end
  endfunction

  assign head_short = (q_head.count > ldf_pkg::CNT_W'(ldf_pkg::MAX_POINTS))
                      || (q_head.count < ldf_pkg::CNT_W'(2));
  assign sweep_end = (idx == n) && !rd_v && !sq_v;
  assign sq_full = rd_data * rd_data;

  assign n_m1 = n - 1'b1;
  assign n_p1 = {1'b0, n} + 1'b1;
  assign nsq = n * n;
  assign nnp1_calc = n * n_p1;
  assign nm1_s0 = $signed({1'b0, n_m1}) * s0;
  assign d_calc = {s1[ldf_pkg::SUM1_W-1], s1, 1'b0} - nm1_s0;
  assign dx_calc = tl - tf;
  assign ts_calc = tf + tl;
  assign pn_calc = $signed({1'b0, n_p1}) * s0;
  assign m_calc = n * nn1;
  assign mden = m * n_m1;

  assign s0_mag = s0[ldf_pkg::SUM0_W-1] ? ldf_pkg::SUM0_W'(-s0) : ldf_pkg::SUM0_W'(s0);
  assign d_mag = d[47] ? 48'(-d) : 48'(d);
  assign d3_mag = {2'b0, d_mag} + {1'b0, d_mag, 1'b0};
  assign dx_mag = dx[32] ? 33'(-dx) : 33'(dx);
  assign ts_mag = ts[32] ? 33'(-ts) : 33'(ts);
  assign pn_mag = pn[47] ? 48'(-pn) : 48'(pn);
  assign den_s = nnp1 * dx_mag;
  assign diff_v = t_a - t_c;

  // Intercept numerator P - Q in sign and magnitude.
  always_comb begin
    p_neg = pn[47] ^ dx[32];
    b_neg = ~(d[47] ^ ts[32]);
    if (p_neg == b_neg) begin
      i_mag = t_b + t_c;
      i_neg = p_neg;
    end else if (t_b >= t_c) begin
      i_mag = t_b - t_c;
      i_neg = p_neg;
    end else begin
      i_mag = t_c - t_b;
      i_neg = b_neg;
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (state)
      ldf_pkg::BK_MUL_A: begin
        mul_a = 128'(syy);
        mul_b = 64'(m);
      end
      ldf_pkg::BK_MUL_B1: begin
        mul_a = 128'(s0_mag);
        mul_b = 64'(s0_mag);
      end
      ldf_pkg::BK_MUL_B2: begin
        mul_a = t_b;
        mul_b = 64'(nn1);
      end
      ldf_pkg::BK_MUL_C: begin
        mul_a = 128'(d_mag);
        mul_b = 64'(d_mag);
      end
      ldf_pkg::BK_MUL_P: begin
        mul_a = 128'(pn_mag);
        mul_b = 64'(dx_mag);
      end
      ldf_pkg::BK_MUL_Q: begin
        mul_a = 128'(d3_mag);
        mul_b = 64'(ts_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign is_mul = (state == ldf_pkg::BK_MUL_A) || (state == ldf_pkg::BK_MUL_B1) ||
                  (state == ldf_pkg::BK_MUL_B2) || (state == ldf_pkg::BK_MUL_C) ||
                  (state == ldf_pkg::BK_MUL_P) || (state == ldf_pkg::BK_MUL_Q);
  assign is_div = (state == ldf_pkg::BK_DIV_V) || (state == ldf_pkg::BK_DIV_S) ||
                  (state == ldf_pkg::BK_DIV_I);
  assign mul_go = is_mul & ~launched;
  assign div_go = is_div & ~launched;

  ldf_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .p    (mul_p)
  );

  ldf_div u_div (
    .clk    (clk),
    .rst    (rst),
    .go     (div_go),
    .num    (t_a),
    .den    (den_v),
    .done   (div_done),
    .quo    (div_q),
    .rem_nz (div_nz)
  );

  assign done = (state == ldf_pkg::BK_OUT);
  assign result = res;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldf_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    pop = 1'b0;
    store_free = 1'b0;
    rd_req.rd_en = (state == ldf_pkg::BK_SWEEP) && (idx < n);
    rd_req.rd_addr = idx[ldf_pkg::ADDR_W-1:0];
    case (state)
      ldf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (head_short) begin
            store_free = 1'b1;
            state_next = ldf_pkg::BK_OUT;
          end else begin
            state_next = ldf_pkg::BK_SWEEP;
          end
        end
      end
      ldf_pkg::BK_SWEEP: begin
        if (sweep_end) begin
          store_free = 1'b1;
          state_next = ldf_pkg::BK_PREP;
        end
      end
      ldf_pkg::BK_PREP:   state_next = ldf_pkg::BK_PREP2;
      ldf_pkg::BK_PREP2:  state_next = ldf_pkg::BK_MUL_A;
      ldf_pkg::BK_MUL_A:  if (mul_done) state_next = ldf_pkg::BK_MUL_B1;
      ldf_pkg::BK_MUL_B1: if (mul_done) state_next = ldf_pkg::BK_MUL_B2;
      ldf_pkg::BK_MUL_B2: if (mul_done) state_next = ldf_pkg::BK_MUL_C;
      ldf_pkg::BK_MUL_C:  if (mul_done) state_next = ldf_pkg::BK_NUM1;
      ldf_pkg::BK_NUM1:   state_next = ldf_pkg::BK_NUM2;
      ldf_pkg::BK_NUM2:   state_next = ldf_pkg::BK_DIV_V;
      ldf_pkg::BK_DIV_V: begin
        if (div_done) begin
          state_next = (dx == '0) ? ldf_pkg::BK_OUT : ldf_pkg::BK_SLOPE;
        end
      end
      ldf_pkg::BK_SLOPE:  state_next = ldf_pkg::BK_DIV_S;
      ldf_pkg::BK_DIV_S:  if (div_done) state_next = ldf_pkg::BK_MUL_P;
      ldf_pkg::BK_MUL_P:  if (mul_done) state_next = ldf_pkg::BK_MUL_Q;
      ldf_pkg::BK_MUL_Q:  if (mul_done) state_next = ldf_pkg::BK_ISUB;
      ldf_pkg::BK_ISUB:   state_next = ldf_pkg::BK_DIV_I;
      ldf_pkg::BK_DIV_I:  if (div_done) state_next = ldf_pkg::BK_OUT;
      ldf_pkg::BK_OUT:    state_next = ldf_pkg::BK_IDLE;
      default:            state_next = ldf_pkg::BK_IDLE;
    endcase
  end

  // Control flags of the sweep pipeline and the shared units.
  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
      rd_v <= 1'b0;
      sq_v <= 1'b0;
    end else begin
      if (mul_go || div_go) begin
        launched <= 1'b1;
      end else if (mul_done || div_done) begin
        launched <= 1'b0;
      end
      rd_v <= rd_req.rd_en;
      sq_v <= rd_v;
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      ldf_pkg::BK_IDLE: begin
        if (!q_empty) begin
          n <= q_head.count;
          s0 <= q_head.s0;
          s1 <= q_head.s1;
          tf <= q_head.t_first;
          tl <= q_head.t_last;
          idx <= '0;
          syy <= '0;
          res.slope <= '0;
          res.intercept <= '0;
          res.residual_variance <= '0;
          if (q_head.count > ldf_pkg::CNT_W'(ldf_pkg::MAX_POINTS)) begin
            res.status <= ldf_pkg::ST_OVFL;
          end else begin
            res.status <= ldf_pkg::ST_FEW;
          end
        end
      end
      ldf_pkg::BK_SWEEP: begin
        if (rd_req.rd_en) begin
          idx <= idx + 1'b1;
        end
        if (rd_v) begin
          sq <= sq_full[46:0];
        end
        if (sq_v) begin
          syy <= syy + 57'(sq);
        end
      end
      ldf_pkg::BK_PREP: begin
        nn1 <= 21'(nsq - 22'd1);
        nnp1 <= nnp1_calc[20:0];
        d <= d_calc;
        dx <= dx_calc;
        ts <= ts_calc;
        pn <= pn_calc;
      end
      ldf_pkg::BK_PREP2: begin
        m <= m_calc[30:0];
      end
      ldf_pkg::BK_MUL_A:  if (mul_done) t_a <= mul_p;
      ldf_pkg::BK_MUL_B1: if (mul_done) t_b <= mul_p;
      ldf_pkg::BK_MUL_B2: if (mul_done) t_b <= mul_p;
      ldf_pkg::BK_MUL_C:  if (mul_done) t_c <= mul_p;
      ldf_pkg::BK_NUM1: begin
        t_a <= t_a - t_b;
        t_c <= t_c + {t_c[126:0], 1'b0};
      end
      ldf_pkg::BK_NUM2: begin
        t_a <= {diff_v[111:0], 16'b0};
        den_v <= 128'(mden);
      end
      ldf_pkg::BK_DIV_V: begin
        if (div_done) begin
          res.residual_variance <= (|div_q[127:64]) ? '1 : div_q[63:0];
          res.status <= (dx == '0) ? ldf_pkg::ST_SPAN : ldf_pkg::ST_OK;
        end
      end
      ldf_pkg::BK_SLOPE: begin
        den_v <= 128'(den_s);
        t_a <= {45'b0, d3_mag, 33'b0};
        neg_s <= d[47] ^ dx[32];
      end
      ldf_pkg::BK_DIV_S: begin
        if (div_done) begin
          res.slope <= sat_quo(div_q, div_nz, neg_s && (t_a != '0));
        end
      end
      ldf_pkg::BK_MUL_P: if (mul_done) t_b <= mul_p;
      ldf_pkg::BK_MUL_Q: if (mul_done) t_c <= mul_p;
      ldf_pkg::BK_ISUB: begin
        t_a <= {i_mag[95:0], 32'b0};
        // The quotient sign also follows the sign of the time span.
        neg_s <= i_neg ^ dx[32];
      end
      ldf_pkg::BK_DIV_I: begin
        if (div_done) begin
          res.intercept <= sat_quo(div_q, div_nz, neg_s && (t_a != '0));
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/linear_detrend_fit_unit.sv -----
// Least-squares line fit over a block of timestamped samples.
//
// Input: a sample transfers at a rising edge where start is high and busy is
// low. The sample marked last_sample closes the block. Samples of one block
// can be sent one per cycle; past 1024 samples the block is flagged.
// Output: one result per block, on result for exactly one cycle while done is
// high. The receiver cannot stall, so nothing backs up on the output side.
// Sequence: after the last sample, busy stays high while the back end sweeps the
// sample store (if the back end is still fitting the previous block, busy holds
// until that fit ends and this block is swept), then the next block may start.
// The result follows the store sweep, six shift-add products and three
// restoring divisions on one shared multiplier and one shared divider. A zero
// time span ends after the variance division. Blocks with fewer than two points
// or an overflowed store finish without a sweep once the back end takes them up.
// A short job queue decouples the sample front end from the fitting back end.
// Reset clears the block count, sums, the queue and the sequencer; the store
// contents are left as they are and only written entries are read.
module linear_detrend_fit_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ldf_pkg::item_t     item,
  output logic               done,
  output ldf_pkg::result_t   result
);

  logic               push;
  ldf_pkg::job_t      job;
  logic               q_empty;
  logic               q_full;
  ldf_pkg::job_t      q_head;
  logic               pop;
  logic               store_free;
  ldf_pkg::rd_req_t   rd_req;
  logic signed [23:0] rd_data;

  ldf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .item       (item),
    .push       (push),
    .job        (job),
    .store_free (store_free),
    .rd_req     (rd_req),
    .rd_data    (rd_data)
  );

  ldf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job),
    .pop   (pop),
    .empty (q_empty),
    .full  (q_full),
    .head  (q_head)
  );

  ldf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .store_free (store_free),
    .rd_req     (rd_req),
    .rd_data    (rd_data),
    .done       (done),
    .result     (result)
  );

  // Result strobes never come back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Flagged blocks carry all-zero numbers.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ldf_pkg::ST_FEW || result.status == ldf_pkg::ST_OVFL)
    |-> result.slope == '0 && result.intercept == '0 &&
        result.residual_variance == '0)
    else $error("flagged block with nonzero fit");

  // Closing a block raises busy to lock the store.
  a_lock_store: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.last_sample |=> busy)
    else $error("store not locked after the closing transfer");

  // A job is never pushed into a full queue.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into a full queue");

endmodule

// ----- verif/tb_linear_detrend_fit_unit.sv -----
`timescale 1ns / 100ps

module tb_linear_detrend_fit_unit;

  typedef logic signed [191:0] wide_t;

  // One row of the directed plan; typed rows carry a hand-written result.
  typedef struct {
    ldf_pkg::item_t   it;
    bit               typed;
    ldf_pkg::result_t res;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  ldf_pkg::item_t   item;
  logic             done;
  ldf_pkg::result_t result;

  // Line-fit predictor state.
  logic signed [23:0] fit_store [ldf_pkg::MAX_POINTS];
  int                 fit_count;
  longint             fit_first;
  longint             fit_last;
  longint             fit_s0;
  longint             fit_s1;

  ldf_pkg::result_t fit_queue [$];
  plan_row_t        plan [$];
  int               mismatches;
  int               burst_left;
  int               sent_items;

  linear_detrend_fit_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // Clock: 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Floor division on wide signed operands.
  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if ((n % d) != 0 && ((n < 0) != (d < 0))) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic logic [63:0] clamp_s64(wide_t q);
    wide_t hi;
    wide_t lo;
    hi = 64'sh7FFF_FFFF_FFFF_FFFF;
    lo = -hi - 1;
    if (q > hi) begin
      return 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (q < lo) begin
      return 64'h8000_0000_0000_0000;
    end
    return q[63:0];
  endfunction

  // Fit of the closed block from the predictor state.
  function automatic ldf_pkg::result_t fit_block();
    ldf_pkg::result_t r;
    wide_t   n, d, dx, m, syy, num, den, q, t;
    r = '0;
    if (fit_count > ldf_pkg::MAX_POINTS) begin
      r.status = ldf_pkg::ST_OVFL;
      return r;
    end
    if (fit_count < 2) begin
      r.status = ldf_pkg::ST_FEW;
      return r;
    end
    n = fit_count;
    d = fit_s1;
    d = d * 2;
    t = fit_s0;
    d = d - (n - 1) * t;
    dx = fit_last - fit_first;
    m = n * (n * n - 1);
    syy = 0;
    for (int j = 0; j < fit_count; j++) begin
      t = fit_store[j];
      syy = syy + t * t;
    end
    t = fit_s0;
    num = m * syy - (n * n - 1) * t * t - 3 * d * d;
    num = num <<< 16;
    q = num / (m * (n - 1));
    r.residual_variance = (q >= (wide_t'(1) <<< 64)) ? '1 : q[63:0];
    if (dx == 0) begin
      r.status = ldf_pkg::ST_SPAN;
      return r;
    end
    r.status = ldf_pkg::ST_OK;
    den = n * (n + 1) * dx;
    num = (6 * d) <<< 32;
    r.slope = clamp_s64(floor_div(num, den));
    q = fit_first + fit_last;
    num = ((n + 1) * t * dx - 3 * d * q) <<< 32;
    r.intercept = clamp_s64(floor_div(num, den));
    return r;
  endfunction

  // Fold one accepted sample into the predictor; true when it closes a block.
  function automatic bit take_sample(ldf_pkg::item_t it, output ldf_pkg::result_t r);
    longint y;
    y = it.sample_value;
    if (fit_count == 0) begin
      fit_first = it.time_stamp;
    end
    fit_last = it.time_stamp;
    if (fit_count < ldf_pkg::MAX_POINTS) begin
      fit_store[fit_count] = it.sample_value;
      fit_s0 += y;
      fit_s1 += longint'(fit_count) * y;
      fit_count++;
    end else begin
      fit_count = ldf_pkg::MAX_POINTS + 1;
    end
    r = '0;
    if (!it.last_sample) begin
      return 1'b0;
    end
    r = fit_block();
    fit_count = 0;
    fit_s0 = 0;
    fit_s1 = 0;
    return 1'b1;
  endfunction

  // Drive one sample and hold it until the transfer, then idle per burst pattern.
  task automatic send_sample(ldf_pkg::item_t it, bit typed, ldf_pkg::result_t typed_res);
    bit               accepted;
    ldf_pkg::result_t r;
    start <= 1'b1;
    item  <= it;
    do begin
      @(negedge clk);
      accepted = !busy;
      @(posedge clk);
    end while (!accepted);
    if (take_sample(it, r)) begin
      fit_queue.push_back(typed ? typed_res : r);
    end
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic plan_row_t mk_row(logic [31:0] ts, logic [23:0] v, bit last,
                                       bit typed, logic [1:0] st);
    plan_row_t p;
    p.it.time_stamp = ts;
    p.it.sample_value = v;
    p.it.last_sample = last;
    p.typed = typed;
    p.res = '0;
    p.res.status = st;
    return p;
  endfunction

  // Check each result transfer against the oldest expectation.
  always @(negedge clk) begin
    ldf_pkg::result_t want;
    if (!rst && done) begin
      if (fit_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result transfer: %p", result);
        end
      end else begin
        want = fit_queue.pop_front();
        if (result.slope !== want.slope || result.intercept !== want.intercept ||
            result.residual_variance !== want.residual_variance ||
            result.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result mismatch: expected slope %h intercept %h var %h status %0d",
                     want.slope, want.intercept, want.residual_variance, want.status);
            $display("                 actual   slope %h intercept %h var %h status %0d",
                     result.slope, result.intercept, result.residual_variance,
                     result.status);
          end
        end
      end
    end
  end

  // Generous overall limit.
  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    ldf_pkg::item_t   it;
    ldf_pkg::result_t none;
    int      len, tmode, vmode, wait_cycles;
    logic [31:0] tcur;

    start = 1'b0;
    item = '0;
    rst = 1'b1;
    none = '0;
    mismatches = 0;
    burst_left = 0;
    sent_items = 0;
    fit_count = 0;
    fit_first = 0;
    fit_last = 0;
    fit_s0 = 0;
    fit_s1 = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan: single points, extremes, zero span, intercept saturation.
    plan.push_back(mk_row(32'd0, 24'd0, 1, 1, ldf_pkg::ST_FEW));
    plan.push_back(mk_row(32'h8000_0000, 24'h7F_FFFF, 0, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'h7FFF_FFFF, 24'h80_0000, 1, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'd5, 24'd100, 0, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'd5, -24'sd100, 1, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'hFFFF_FFFF, 24'h80_0000, 0, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'd0, 24'h7F_FFFF, 0, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'd1, 24'h80_0000, 1, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'h7FFF_FFFE, 24'h80_0000, 0, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'h7FFF_FFFF, 24'h7F_FFFF, 1, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'h8000_0000, 24'h80_0000, 1, 1, ldf_pkg::ST_FEW));
    plan.push_back(mk_row(32'h8000_0000, 24'h7F_FFFF, 0, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'h8000_0001, 24'h7F_FFFF, 0, 0, ldf_pkg::ST_OK));
    plan.push_back(mk_row(32'h8000_0002, 24'h7F_FFFF, 1, 0, ldf_pkg::ST_OK));
    foreach (plan[i]) begin
      send_sample(plan[i].it, plan[i].typed, plan[i].res);
    end

    // Store overflow, then a block that fills the store exactly.
    for (int i = 0; i <= ldf_pkg::MAX_POINTS + 1; i++) begin
      it.time_stamp = i;
      it.sample_value = 24'($urandom);
      it.last_sample = (i == ldf_pkg::MAX_POINTS + 1);
      send_sample(it, it.last_sample, '{64'd0, 64'd0, 64'd0, ldf_pkg::ST_OVFL});
    end
    for (int i = 0; i < ldf_pkg::MAX_POINTS; i++) begin
      it.time_stamp = 32'h7000_0000 + i * 3;
      it.sample_value = 24'($urandom);
      it.last_sample = (i == ldf_pkg::MAX_POINTS - 1);
      send_sample(it, 1'b0, none);
    end

    // Random blocks, mostly small, with varied timing and value profiles.
    sent_items = 0;
    while (sent_items < 700) begin
      case ($urandom_range(0, 19))
        0:       len = 1;
        1, 2, 3: len = $urandom_range(13, 64);
        default: len = $urandom_range(2, 12);
      endcase
      tmode = $urandom_range(0, 3);
      vmode = $urandom_range(0, 2);
      tcur = $urandom;
      for (int i = 0; i < len; i++) begin
        case (tmode)
          0: tcur = tcur + $urandom_range(1, 1000);
          1: tcur = $urandom;
          2: tcur = tcur;
          default: tcur = tcur + 1;
        endcase
        it.time_stamp = tcur;
        case (vmode)
          0: it.sample_value = 24'($urandom);
          1: it.sample_value = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
          default: it.sample_value = 24'($urandom_range(0, 200) - 100);
        endcase
        it.last_sample = (i == len - 1);
        send_sample(it, 1'b0, none);
      end
    end
    start <= 1'b0;

    // Drain: wait for every expected result, then a short settle.
    wait_cycles = 0;
    while (fit_queue.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (fit_queue.size() != 0) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      repeat (1200) @(posedge clk);
      if (mismatches == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
      $finish;
    end
  end

endmodule

// ----- files.f -----
sv/ldf_pkg.sv
sv/ldf_front.sv
sv/ldf_queue.sv
sv/ldf_mul.sv
sv/ldf_div.sv
sv/ldf_back.sv
sv/linear_detrend_fit_unit.sv
verif/tb_linear_detrend_fit_unit.sv
